// ----- sv/ostba_pkg.sv -----
// ----------------------------------------------------------------------------
// ostba_pkg
// Shared types, constants and helpers for the one-shot timer bank.
// ----------------------------------------------------------------------------
package ostba_pkg;

   // bank geometry
   localparam int NUM_SLOTS  = 8;
   localparam int COUNT_BITS = 16;
   localparam int SLOT_BITS  = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

   // item kind codes
   localparam logic FUNC_TICK   = 1'b0;
   localparam logic FUNC_START  = 1'b1;
   localparam logic KIND_START  = 1'b0;
   localparam logic KIND_EXPIRY = 1'b1;

   typedef logic [NUM_SLOTS-1:0]  mask_type;
   typedef logic [SLOT_BITS-1:0]  slot_idx_type;
   typedef logic [COUNT_BITS-1:0] count_type;

   // input item
   typedef struct packed {
      logic        func;
      logic [15:0] delay;
      logic        deferred_mode;
      logic [7:0]  priority_req;
      logic [7:0]  callback_id;
   } req_type;

   // result item
   typedef struct packed {
      logic       kind;
      logic [2:0] slot;
      logic       start_failed;
      logic [7:0] fired_callback;
      logic [7:0] fired_priority;
      logic       fired_deferred;
      logic       last;
   } rsp_type;

   // controller -> datapath
   typedef struct packed {
      logic start_go;     // allocate a slot for the incoming item
      logic tick_go;      // decrement all active slots
      logic load_start;   // move start answer into the output register
      logic load_expiry;  // move lowest pending expiry into the output register
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic out_free;     // output register can take a result this cycle
      logic pend_any;     // expiries still to report
      logic pend_one;     // at most one expiry left
   } status_type;

   // lowest set bit search
   typedef struct packed {
      logic         found;
      slot_idx_type idx;
   } pick_type;

   function automatic pick_type find_first(input mask_type mask);
      pick_type r;
      r.found = 1'b0;
      r.idx   = '0;
      for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
         if (mask[i]) begin
            r.found = 1'b1;
            r.idx   = SLOT_BITS'(i);
         end
      end
      return r;
   endfunction

endpackage

// ----- sv/ostba_ctrl.sv -----
// ----------------------------------------------------------------------------
// ostba_ctrl
// Sequencer: takes one item at a time and steers result delivery.
// ----------------------------------------------------------------------------
module ostba_ctrl
   import ostba_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic       req_func,
   output logic       req_stall,
   input  status_type status,
   output cmd_type    cmd
);

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_START  = 2'd1;
   localparam logic [1:0] ST_EXPIRE = 2'd2;

   logic [1:0] state_ff, state_in;

   assign req_stall = (state_ff != ST_IDLE);

   // next state and commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (req_func == FUNC_START) begin
                  cmd.start_go = 1'b1;
                  state_in     = ST_START;
               end else begin
                  cmd.tick_go  = 1'b1;
                  state_in     = ST_EXPIRE;
               end
            end
         end
         ST_START: begin
            if (status.out_free) begin
               cmd.load_start = 1'b1;
               state_in       = ST_IDLE;
            end
         end
         ST_EXPIRE: begin
            if (!status.pend_any) begin
               state_in = ST_IDLE;
            end else if (status.out_free) begin
               cmd.load_expiry = 1'b1;
               if (status.pend_one) state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else       state_ff <= state_in;
   end

endmodule

// ----- sv/ostba_dp.sv -----
// ----------------------------------------------------------------------------
// ostba_dp
// Slot storage, per-slot down counters, pending expiry mask, output register.
// ----------------------------------------------------------------------------
module ostba_dp
   import ostba_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  req_type    req_data,
   input  cmd_type    cmd,
   output status_type status,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output rsp_type    rsp_data
);

   mask_type   active_ff, active_in;
   mask_type   deferred_ff, deferred_in;
   mask_type   pend_ff, pend_in;
   count_type  cnt_ff [NUM_SLOTS];
   logic [7:0] prio_ff [NUM_SLOTS];
   logic [7:0] cb_ff [NUM_SLOTS];
   slot_idx_type st_slot_ff;
   logic         st_fail_ff;
   logic         rsp_valid_ff, rsp_valid_in;
   rsp_type      rsp_data_ff, rsp_data_in;

   pick_type   free_pick;
   pick_type   pend_pick;
   mask_type   expire_now;
   mask_type   pend_rest;

   assign free_pick = find_first(~active_ff);
   assign pend_pick = find_first(pend_ff);

   // slots that hit zero on this tick
   always_comb begin
      for (int i = 0; i < NUM_SLOTS; i++) begin
         expire_now[i] = active_ff[i] && (cnt_ff[i] == count_type'(1));
      end
   end

   always_comb begin
      pend_rest = pend_ff;
      pend_rest[pend_pick.idx] = 1'b0;
   end

   assign status.out_free = !rsp_valid_ff || !rsp_stall;
   assign status.pend_any = |pend_ff;
   assign status.pend_one = (pend_rest == '0);

   // slot masks and pending expiries
   always_comb begin
      active_in   = active_ff;
      deferred_in = deferred_ff;
      pend_in     = pend_ff;
      if (cmd.start_go && free_pick.found) begin
         active_in[free_pick.idx]   = 1'b1;
         deferred_in[free_pick.idx] = req_data.deferred_mode;
      end
      if (cmd.tick_go) begin
         active_in = active_ff & ~expire_now;
         pend_in   = expire_now;
      end
      if (cmd.load_expiry) pend_in = pend_rest;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff   <= '0;
         deferred_ff <= '0;
         pend_ff     <= '0;
      end else begin
         active_ff   <= active_in;
         deferred_ff <= deferred_in;
         pend_ff     <= pend_in;
      end
   end

   // per-slot counters and payload
   always_ff @(posedge clock) begin
      for (int i = 0; i < NUM_SLOTS; i++) begin
         if (cmd.start_go && free_pick.found && free_pick.idx == SLOT_BITS'(i)) begin
            cnt_ff[i]  <= count_type'(req_data.delay);
            cb_ff[i]   <= req_data.callback_id;
            prio_ff[i] <= req_data.priority_req;
         end else if (cmd.tick_go && active_ff[i]) begin
            cnt_ff[i] <= cnt_ff[i] - count_type'(1);
         end
      end
   end

   // held start answer
   always_ff @(posedge clock) begin
      if (cmd.start_go) begin
         st_slot_ff <= free_pick.found ? free_pick.idx : '0;
         st_fail_ff <= !free_pick.found;
      end
   end

   // output register
   always_comb begin
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (cmd.load_start) begin
         rsp_valid_in               = 1'b1;
         rsp_data_in.kind           = KIND_START;
         rsp_data_in.slot           = 3'(st_slot_ff);
         rsp_data_in.start_failed   = st_fail_ff;
         rsp_data_in.fired_callback = '0;
         rsp_data_in.fired_priority = '0;
         rsp_data_in.fired_deferred = 1'b0;
         rsp_data_in.last           = 1'b1;
      end else if (cmd.load_expiry) begin
         rsp_valid_in               = 1'b1;
         rsp_data_in.kind           = KIND_EXPIRY;
         rsp_data_in.slot           = 3'(pend_pick.idx);
         rsp_data_in.start_failed   = 1'b0;
         rsp_data_in.fired_callback = cb_ff[pend_pick.idx];
         rsp_data_in.fired_priority = deferred_ff[pend_pick.idx] ?
                                      prio_ff[pend_pick.idx] : 8'd0;
         rsp_data_in.fired_deferred = deferred_ff[pend_pick.idx];
         rsp_data_in.last           = (pend_rest == '0);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else       rsp_valid_ff <= rsp_valid_in;
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ----- sv/one_shot_timer_bank_alloc.sv -----
// ----------------------------------------------------------------------------
// one_shot_timer_bank_alloc
// A start answer is held in a register when the item is taken, then moved into the
// output register once that is free. A tick decrements all active slots at its accept
// edge; expiries then leave the output register one per cycle in ascending slot order
// while rsp_stall does not hold it. No new item is taken until the start answer or
// every expiry of a tick is in the single output register; rsp_stall holds this up.
// Reset: all slots free, no result pending.
// ----------------------------------------------------------------------------
module one_shot_timer_bank_alloc
   import ostba_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   cmd_type    cmd;
   status_type status;

   // sequencer
   ostba_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_func  (req_data.func),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // slot bank
   ostba_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cmd       (cmd),
      .status    (status),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule
